>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; bodies vanish when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/pcsc_pkg.sv
// shared constants, codes and types for the traffic statistics counter
// no dependencies
package pcsc_pkg;

    localparam int PORT_BITS   = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int LENGTH_BITS = 16;

    localparam int PORT_SLOTS = 1 << PORT_BITS;
    localparam int BYTE_WIDTH = 48;
    localparam int PCT_BITS   = 15;
    localparam int MUL_W      = COUNT_WIDTH + PCT_BITS;
    localparam int DIV_W      = (BYTE_WIDTH > MUL_W) ? BYTE_WIDTH : MUL_W;
    localparam int CLASS_COUNT = 12;

    localparam logic [PCT_BITS-1:0] PCT_SCALE = 15'd25600;

    // input kinds
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_STAT  = 2'd1;
    localparam logic [1:0] KIND_PCT   = 2'd2;
    localparam logic [1:0] KIND_PORT  = 2'd3;

    // statistic selects
    localparam logic [4:0] SEL_FRAMES      = 5'd0;
    localparam logic [4:0] SEL_BYTES       = 5'd1;
    localparam logic [4:0] SEL_MIN         = 5'd2;
    localparam logic [4:0] SEL_MAX         = 5'd3;
    localparam logic [4:0] SEL_AVG         = 5'd4;
    localparam logic [4:0] SEL_FIRST_CLASS = 5'd5;
    localparam logic [4:0] SEL_LAST_CLASS  = 5'd16;

    // class counter slots
    localparam int C_ARP_REQ  = 0;
    localparam int C_ARP_REP  = 1;
    localparam int C_ICMP_REQ = 2;
    localparam int C_ICMP_REP = 3;
    localparam int C_ICMP_ALL = 4;
    localparam int C_TCP      = 5;
    localparam int C_UDP      = 6;
    localparam int C_TCP_ACK  = 7;
    localparam int C_HTTP     = 8;
    localparam int C_DNS      = 9;
    localparam int C_HTTPS    = 10;
    localparam int C_NTP      = 11;

    // header codes
    localparam logic [15:0] ET_ARP     = 16'h0806;
    localparam logic [15:0] ET_IPV4    = 16'h0800;
    localparam logic [15:0] ARP_REQ    = 16'h0001;
    localparam logic [15:0] ARP_REP    = 16'h0002;
    localparam logic [7:0]  PROTO_ICMP = 8'h01;
    localparam logic [7:0]  PROTO_TCP  = 8'h06;
    localparam logic [7:0]  PROTO_UDP  = 8'h11;
    localparam logic [7:0]  ICMP_REP   = 8'h00;
    localparam logic [7:0]  ICMP_REQ   = 8'h08;

    // register indexes and reset values
    localparam logic [1:0] REG_HTTP  = 2'd0;
    localparam logic [1:0] REG_DNS   = 2'd1;
    localparam logic [1:0] REG_HTTPS = 2'd2;
    localparam logic [1:0] REG_NTP   = 2'd3;
    localparam logic [15:0] HTTP_RST  = 16'd80;
    localparam logic [15:0] DNS_RST   = 16'd53;
    localparam logic [15:0] HTTPS_RST = 16'd443;
    localparam logic [15:0] NTP_RST   = 16'd123;

    typedef struct packed {
        logic                   en;
        logic                   both;
        logic                   udp;
        logic [PORT_BITS-1:0]   addr;
        logic [COUNT_WIDTH-1:0] data;
    } ram_wr_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

>>> hw/rtl/pcsc_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on pcsc_pkg
module pcsc_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [pcsc_pkg::DIV_W-1:0]      dividend,
    input  logic [pcsc_pkg::COUNT_WIDTH-1:0] divisor,
    output logic                            done,
    output logic [pcsc_pkg::DIV_W-1:0]      quotient
);
    import pcsc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic [COUNT_WIDTH-1:0] den_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [COUNT_WIDTH:0]   trial;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = COUNT_WIDTH'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[COUNT_WIDTH-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) den_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/pcsc_port_table.sv
// per-destination-port counters for tcp and udp, one memory each
// depends on pcsc_pkg
module pcsc_port_table (
    input  logic                             aclk,
    input  logic                             rd_en,
    input  logic                             rd_udp,
    input  logic [pcsc_pkg::PORT_BITS-1:0]   rd_addr,
    output logic [pcsc_pkg::COUNT_WIDTH-1:0] rd_data,
    input  pcsc_pkg::ram_wr_t                wr
);
    import pcsc_pkg::*;

    logic [COUNT_WIDTH-1:0] tcp_mem [PORT_SLOTS];
    logic [COUNT_WIDTH-1:0] udp_mem [PORT_SLOTS];
    logic [COUNT_WIDTH-1:0] tcp_q_reg, udp_q_reg;
    logic                   sel_reg;

    always_ff @(posedge aclk) begin
        if (wr.en && (wr.both || !wr.udp)) tcp_mem[wr.addr] <= wr.data;
        if (wr.en && (wr.both || wr.udp))  udp_mem[wr.addr] <= wr.data;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            tcp_q_reg <= tcp_mem[rd_addr];
            udp_q_reg <= udp_mem[rd_addr];
            sel_reg   <= rd_udp;
        end
    end

    assign rd_data = sel_reg ? udp_q_reg : tcp_q_reg;

endmodule

>>> hw/rtl/packet_class_stats_counter.sv
// top level of the traffic statistics counter: sequencer, totals, class counters
// depends on pcsc_pkg, pcsc_divider, pcsc_port_table, assert_macros.svh
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_kind .. s_port_is_udp (one word per frame/read)
//  m_        out        m_valid / m_ready    m_read_value, m_read_error
//  cfg_      in         cfg_we               cfg_index, cfg_wdata (no read-back)
//
// sequence: a frame word is decoded, then a tcp or udp frame read-modify-writes its port
//   memory entry; average and percentage (a multiply, then a divide) use the shared
//   divider that retires one quotient bit per cycle over 48 bits
// reset: after aresetn the port memories are cleared one entry per cycle, all 65536 entries,
//   with s_ready low; config writes are taken meanwhile
// stalls: a finished result waits in the output register while the next word is taken
`include "assert_macros.svh"
module packet_class_stats_counter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [15:0] s_frame_length,
    input  logic [15:0] s_eth_tag,
    input  logic [15:0] s_arp_opcode,
    input  logic [7:0]  s_ip_proto,
    input  logic [7:0]  s_icmp_msg,
    input  logic        s_tcp_ack,
    input  logic        s_tcp_syn,
    input  logic [15:0] s_dest_port,
    input  logic [4:0]  s_stat_select,
    input  logic        s_port_is_udp,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_read_value,
    output logic        m_read_error,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import pcsc_pkg::*;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DECODE    = 4'd2;
    localparam logic [3:0] S_FRAME_WR  = 4'd3;
    localparam logic [3:0] S_PORT_DATA = 4'd4;
    localparam logic [3:0] S_MUL       = 4'd5;
    localparam logic [3:0] S_DIV_START = 4'd6;
    localparam logic [3:0] S_DIV_WAIT  = 4'd7;
    localparam logic [3:0] S_RESULT    = 4'd8;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic [3:0] state_reg, state_next;
    logic [PORT_BITS:0] clr_reg, clr_next;

    // config registers
    logic [15:0] http_reg, dns_reg, https_reg, ntp_reg;

    // latched input word
    logic [1:0]  kind_reg;
    logic [15:0] len_reg, et_reg, op_reg, port_reg;
    logic [7:0]  proto_reg, itype_reg;
    logic        ack_reg, syn_reg, udp_reg;
    logic [4:0]  sel_reg;

    // statistics
    logic [COUNT_WIDTH-1:0] frame_total_reg;
    logic [BYTE_WIDTH-1:0]  byte_total_reg;
    logic [LENGTH_BITS-1:0] length_min_reg, length_max_reg;
    logic [COUNT_WIDTH-1:0] class_reg [CLASS_COUNT];

    // result staging and output register
    logic [BYTE_WIDTH-1:0] res_value_reg, res_value_next;
    logic                  res_err_reg, res_err_next;
    logic                  m_valid_reg;
    logic [BYTE_WIDTH-1:0] m_value_reg;
    logic                  m_err_reg;
    logic [MUL_W-1:0]      product_reg;

    // divider and port memory hookup
    logic                   div_start, div_done;
    logic [DIV_W-1:0]       div_dividend, div_quotient;
    logic                   rd_en, rd_udp;
    logic [COUNT_WIDTH-1:0] rd_data;
    ram_wr_t                wr;

    // decode of the latched word
    logic [LENGTH_BITS-1:0] len_sat;
    logic [BYTE_WIDTH:0]    byte_sum;
    logic                   port_in_range, is_ipv4, is_tcp, is_udp, is_class;
    logic [3:0]             class_idx;
    logic [CLASS_COUNT-1:0] class_hit;
    logic [BYTE_WIDTH-1:0]  stat_value;
    logic                   out_free;

    pcsc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (frame_total_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    pcsc_port_table u_ports (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_udp  (rd_udp),
        .rd_addr (port_reg[PORT_BITS-1:0]),
        .rd_data (rd_data),
        .wr      (wr)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    // saturate long frames to the length field width
    assign len_sat = (32'(len_reg) > 32'(LEN_MAX)) ? LEN_MAX : len_reg[LENGTH_BITS-1:0];
    assign byte_sum = {1'b0, byte_total_reg} + (BYTE_WIDTH+1)'(len_sat);

    assign port_in_range = (32'(port_reg) >> PORT_BITS) == 32'd0;
    assign is_ipv4   = (et_reg == ET_IPV4);
    assign is_tcp    = is_ipv4 && (proto_reg == PROTO_TCP);
    assign is_udp    = is_ipv4 && (proto_reg == PROTO_UDP);
    assign is_class  = (sel_reg >= SEL_FIRST_CLASS) && (sel_reg <= SEL_LAST_CLASS);
    assign class_idx = 4'(sel_reg - SEL_FIRST_CLASS);

    // which class counters one frame bumps
    always_comb begin
        class_hit = '0;
        if (et_reg == ET_ARP) begin
            class_hit[C_ARP_REQ] = (op_reg == ARP_REQ);
            class_hit[C_ARP_REP] = (op_reg == ARP_REP);
        end
        if (is_ipv4 && proto_reg == PROTO_ICMP) begin
            class_hit[C_ICMP_REP] = (itype_reg == ICMP_REP);
            class_hit[C_ICMP_REQ] = (itype_reg == ICMP_REQ);
            class_hit[C_ICMP_ALL] = 1'b1;
        end
        class_hit[C_TCP]     = is_tcp;
        class_hit[C_UDP]     = is_udp;
        class_hit[C_TCP_ACK] = is_tcp && ack_reg && !syn_reg;
        // application ports, first match wins
        if (is_tcp || is_udp) begin
            if (port_reg == http_reg)       class_hit[C_HTTP]  = 1'b1;
            else if (port_reg == dns_reg)   class_hit[C_DNS]   = 1'b1;
            else if (port_reg == https_reg) class_hit[C_HTTPS] = 1'b1;
            else if (port_reg == ntp_reg)   class_hit[C_NTP]   = 1'b1;
        end
    end

    // plain statistic mux
    always_comb begin
        stat_value = '0;
        unique case (sel_reg)
            SEL_FRAMES: stat_value = BYTE_WIDTH'(frame_total_reg);
            SEL_BYTES:  stat_value = byte_total_reg;
            SEL_MIN:    stat_value = BYTE_WIDTH'(length_min_reg);
            SEL_MAX:    stat_value = BYTE_WIDTH'(length_max_reg);
            default:    stat_value = is_class ? BYTE_WIDTH'(class_reg[class_idx]) : '0;
        endcase
    end

    assign div_dividend = (kind_reg == KIND_PCT) ? DIV_W'(product_reg)
                                                 : DIV_W'(byte_total_reg);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        res_value_next = res_value_reg;
        res_err_next   = res_err_reg;
        div_start      = 1'b0;
        rd_en          = 1'b0;
        rd_udp         = udp_reg;
        wr             = '0;
        unique case (state_reg)
            S_CLEAR: begin
                wr.en    = 1'b1;
                wr.both  = 1'b1;
                wr.addr  = clr_reg[PORT_BITS-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (PORT_BITS+1)'(PORT_SLOTS - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                res_value_next = '0;
                res_err_next   = 1'b0;
                unique case (kind_reg)
                    KIND_FRAME: begin
                        rd_en  = 1'b1;
                        rd_udp = is_udp;
                        state_next = ((is_tcp || is_udp) && port_in_range) ? S_FRAME_WR
                                                                            : S_IDLE;
                    end
                    KIND_STAT: begin
                        if (sel_reg == SEL_AVG) begin
                            state_next = (frame_total_reg != '0) ? S_DIV_START : S_RESULT;
                        end else begin
                            res_value_next = stat_value;
                            res_err_next   = (sel_reg > SEL_AVG) && !is_class;
                            state_next     = S_RESULT;
                        end
                    end
                    KIND_PCT: begin
                        if (!is_class || frame_total_reg == '0) begin
                            res_err_next = 1'b1;
                            state_next   = S_RESULT;
                        end else begin
                            state_next = S_MUL;
                        end
                    end
                    default: begin
                        if (!port_in_range) begin
                            res_err_next = 1'b1;
                            state_next   = S_RESULT;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = S_PORT_DATA;
                        end
                    end
                endcase
            end
            S_FRAME_WR: begin
                wr.en   = 1'b1;
                wr.udp  = is_udp;
                wr.addr = port_reg[PORT_BITS-1:0];
                wr.data = sat_inc(rd_data);
                state_next = S_IDLE;
            end
            S_PORT_DATA: begin
                res_value_next = BYTE_WIDTH'(rd_data);
                state_next     = S_RESULT;
            end
            S_MUL: begin
                state_next = S_DIV_START;
            end
            S_DIV_START: begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    res_value_next = div_quotient[BYTE_WIDTH-1:0];
                    state_next     = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            http_reg        <= HTTP_RST;
            dns_reg         <= DNS_RST;
            https_reg       <= HTTPS_RST;
            ntp_reg         <= NTP_RST;
            frame_total_reg <= '0;
            byte_total_reg  <= '0;
            length_min_reg  <= LEN_MAX;
            length_max_reg  <= '0;
            for (int i = 0; i < CLASS_COUNT; i++) class_reg[i] <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_HTTP:  http_reg  <= cfg_wdata;
                    REG_DNS:   dns_reg   <= cfg_wdata;
                    REG_HTTPS: https_reg <= cfg_wdata;
                    default:   ntp_reg   <= cfg_wdata;
                endcase
            end
            // totals and class counters update together in the decode state of the frame
            if (state_reg == S_DECODE && kind_reg == KIND_FRAME) begin
                frame_total_reg <= sat_inc(frame_total_reg);
                byte_total_reg  <= byte_sum[BYTE_WIDTH] ? '1 : byte_sum[BYTE_WIDTH-1:0];
                if (len_sat > length_max_reg) length_max_reg <= len_sat;
                if (len_sat < length_min_reg) length_min_reg <= len_sat;
                for (int i = 0; i < CLASS_COUNT; i++) begin
                    if (class_hit[i]) class_reg[i] <= sat_inc(class_reg[i]);
                end
            end
            if (state_reg == S_RESULT && out_free) m_valid_reg <= 1'b1;
            else if (m_ready)                      m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg  <= s_kind;
            len_reg   <= s_frame_length;
            et_reg    <= s_eth_tag;
            op_reg    <= s_arp_opcode;
            proto_reg <= s_ip_proto;
            itype_reg <= s_icmp_msg;
            ack_reg   <= s_tcp_ack;
            syn_reg   <= s_tcp_syn;
            port_reg  <= s_dest_port;
            sel_reg   <= s_stat_select;
            udp_reg   <= s_port_is_udp;
        end
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
        // class share scaled by 25600 ahead of the divide
        if (state_reg == S_MUL)
            product_reg <= MUL_W'(class_reg[class_idx]) * MUL_W'(PCT_SCALE);
        if (state_reg == S_RESULT && out_free) begin
            m_value_reg <= res_err_reg ? '0 : res_value_reg;
            m_err_reg   <= res_err_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_value_reg;
    assign m_read_error = m_err_reg;

    // no word taken while the port memories are cleared
    `ASSERT_IMPLIES(a_clear_blocks, aclk, aresetn, state_reg == S_CLEAR, !s_ready)
    // an error word carries a zero value
    `ASSERT_IMPLIES(a_err_zero, aclk, aresetn, m_valid && m_read_error, m_read_value == '0)
    // the divider only finishes while the sequencer waits on it
    `ASSERT_IMPLIES(a_div_done, aclk, aresetn, div_done, state_reg == S_DIV_WAIT)
    // once a frame is counted, min never exceeds max
    `ASSERT_IMPLIES(a_min_max, aclk, aresetn, frame_total_reg != '0,
                    length_min_reg <= length_max_reg)

endmodule
